// File: hw/rtl/cdg_pkg.sv
// Package for the clamped decimal glyph field unit.
// Transaction types, queue entry type, glyph codes and the powers-of-ten table.
// No dependencies.
`timescale 1ns / 1ps

package cdg_pkg;

    localparam int          CNT_W        = 4;
    localparam logic [3:0]  MINUS_GLYPH  = 4'd10;
    localparam logic [31:0] JUSTIFY_BIAS = 32'd2;

    localparam logic signed [31:0] W1_LO = 32'sd0;
    localparam logic signed [31:0] W1_HI = 32'sd9;
    localparam logic signed [31:0] W2_LO = -32'sd9;
    localparam logic signed [31:0] W2_HI = 32'sd99;
    localparam logic signed [31:0] W3_LO = -32'sd99;
    localparam logic signed [31:0] W3_HI = 32'sd999;
    localparam logic signed [31:0] W4_LO = -32'sd999;
    localparam logic signed [31:0] W4_HI = 32'sd9999;

    typedef struct packed {
        logic signed [7:0]  field_width;
        logic signed [31:0] start_x;
        logic signed [31:0] number;
        logic [15:0]        advance;
        logic               draw_enable;
        logic               left_align;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         glyph_index;
        logic signed [31:0] glyph_x;
        logic signed [31:0] field_start;
        logic               drawn;
        logic               empty_field;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic             empty;
        logic             neg;
        logic [31:0]      mag;
        logic [CNT_W-1:0] ndig;
        logic [CNT_W-1:0] glyphs;
        logic [31:0]      start_x;
        logic [15:0]      advance;
        logic             draw;
        logic             left;
    } cdg_entry_t;

    function automatic logic [31:0] ten_pow(input logic [CNT_W-1:0] p);
        logic [31:0] r;
        case (p)
            4'd0:    r = 32'd1;
            4'd1:    r = 32'd10;
            4'd2:    r = 32'd100;
            4'd3:    r = 32'd1000;
            4'd4:    r = 32'd10000;
            4'd5:    r = 32'd100000;
            4'd6:    r = 32'd1000000;
            4'd7:    r = 32'd10000000;
            4'd8:    r = 32'd100000000;
            4'd9:    r = 32'd1000000000;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/cdg_front.sv
// Front end: accepts field transactions, caps the width, clamps the value
// and classifies it (sign, magnitude, digit count, glyph count). Uses cdg_pkg.
`timescale 1ns / 1ps

module cdg_front
    import cdg_pkg::*;
#(
    parameter int MAX_DIGITS = 5
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  in_item_t   item,
    input  logic       q_full,
    output logic       push,
    output cdg_entry_t entry
);

    localparam logic signed [7:0] CAP = 8'(MAX_DIGITS);

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_empty_reg, s1_empty_next;
    logic [CNT_W-1:0]    s1_fw_reg, s1_fw_next;
    logic signed [31:0]  s1_val_reg, s1_val_next;
    logic [31:0]         s1_x_reg, s1_x_next;
    logic [15:0]         s1_adv_reg, s1_adv_next;
    logic                s1_draw_reg, s1_draw_next;
    logic                s1_left_reg, s1_left_next;

    logic [CNT_W-1:0]    fw_cap;
    logic signed [31:0]  lo, hi, clamped;
    logic                clamp_on;
    logic                neg;
    logic [31:0]         mag;
    logic [CNT_W-1:0]    ndig, total;

    assign item_stall = s1_valid_reg && q_full;
    assign push       = s1_valid_reg && !q_full;

    always_comb
    begin
        fw_cap = (item.field_width > CAP) ? CNT_W'(MAX_DIGITS) : item.field_width[CNT_W-1:0];
        clamp_on = 1'b1;
        lo = W1_LO;
        hi = W1_HI;
        case (fw_cap)
            4'd1:    begin lo = W1_LO; hi = W1_HI; end
            4'd2:    begin lo = W2_LO; hi = W2_HI; end
            4'd3:    begin lo = W3_LO; hi = W3_HI; end
            4'd4:    begin lo = W4_LO; hi = W4_HI; end
            default: clamp_on = 1'b0;
        endcase
        clamped = item.number;
        if (clamp_on)
        begin
            if (item.number > hi)
                clamped = hi;
            if (item.number < lo)
                clamped = lo;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_empty_next = s1_empty_reg;
        s1_fw_next    = s1_fw_reg;
        s1_val_next   = s1_val_reg;
        s1_x_next     = s1_x_reg;
        s1_adv_next   = s1_adv_reg;
        s1_draw_next  = s1_draw_reg;
        s1_left_next  = s1_left_reg;
        if (!item_stall)
        begin
            s1_valid_next = item_valid;
            s1_empty_next = (item.field_width < 8'sd1);
            s1_fw_next    = fw_cap;
            s1_val_next   = clamped;
            s1_x_next     = item.start_x;
            s1_adv_next   = item.advance;
            s1_draw_next  = item.draw_enable;
            s1_left_next  = item.left_align;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        s1_empty_reg <= s1_empty_next;
        s1_fw_reg    <= s1_fw_next;
        s1_val_reg   <= s1_val_next;
        s1_x_reg     <= s1_x_next;
        s1_adv_reg   <= s1_adv_next;
        s1_draw_reg  <= s1_draw_next;
        s1_left_reg  <= s1_left_next;
    end

    always_comb
    begin
        neg  = s1_val_reg[31];
        mag  = neg ? (32'd0 - s1_val_reg) : s1_val_reg;
        ndig = CNT_W'(1);
        for (int p = 1; p < 10; p++)
        begin
            if (mag >= ten_pow(CNT_W'(p)))
                ndig = CNT_W'(p + 1);
        end
        total = ndig + CNT_W'(neg);

        entry.empty   = s1_empty_reg;
        entry.neg     = neg;
        entry.mag     = mag;
        entry.ndig    = ndig;
        entry.glyphs  = (total < s1_fw_reg) ? total : s1_fw_reg;
        entry.start_x = s1_x_reg;
        entry.advance = s1_adv_reg;
        entry.draw    = s1_draw_reg;
        entry.left    = s1_left_reg;
    end

    property p_hold_when_full;
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg && q_full |=> s1_valid_reg && $stable(s1_val_reg) && $stable(s1_fw_reg);
    endproperty
    a_hold_when_full: assert property (p_hold_when_full)
        else $error("front stage changed while queue full");

    property p_glyphs_bounded;
        @(posedge clk) disable iff (!rst_n)
        push && !entry.empty |-> entry.glyphs != 0 && entry.glyphs <= CNT_W'(MAX_DIGITS);
    endproperty
    a_glyphs_bounded: assert property (p_glyphs_bounded)
        else $error("glyph count out of range");

    property p_ndig_bounded;
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ndig >= 4'd1 && ndig <= 4'd10;
    endproperty
    a_ndig_bounded: assert property (p_ndig_bounded)
        else $error("digit count out of range");

endmodule

// File: hw/rtl/cdg_queue.sv
// Two-entry queue between front and back end.
// Uses cdg_pkg for the entry type.
`timescale 1ns / 1ps

module cdg_queue
    import cdg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cdg_entry_t din,
    input  logic       pop,
    output logic       full,
    output logic       nonempty,
    output cdg_entry_t head
);

    cdg_entry_t mem_reg [2];
    cdg_entry_t mem_next [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign nonempty = (cnt_reg != 2'd0);
    assign head     = mem_reg[rd_reg];

    always_comb
    begin
        mem_next[0] = mem_reg[0];
        mem_next[1] = mem_reg[1];
        wr_next     = wr_reg;
        rd_next     = rd_reg;
        if (push)
        begin
            mem_next[wr_reg] = din;
            wr_next          = ~wr_reg;
        end
        if (pop)
            rd_next = ~rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mem_reg[0] <= mem_next[0];
        mem_reg[1] <= mem_next[1];
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full || pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> nonempty)
        else $error("queue pop while empty");
    a_count_ok: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count corrupt");

endmodule

// File: hw/rtl/cdg_back.sv
// Back end: glyph sequencer, one glyph transaction per cycle while glyph_stall
// is low, most significant digit first, into a registered output. Uses cdg_pkg.
`timescale 1ns / 1ps

module cdg_back
    import cdg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_nonempty,
    input  cdg_entry_t head,
    output logic       pop,
    output logic       glyph_valid,
    input  logic       glyph_stall,
    output out_item_t  glyph
);

    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;
    logic             act_reg, act_next;
    logic             empty_reg, empty_next;
    logic             negp_reg, negp_next;
    logic [31:0]      rem_reg, rem_next;
    logic [CNT_W-1:0] pow_reg, pow_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [31:0]      pen_reg, pen_next;
    logic [31:0]      xpos_reg, xpos_next;
    logic [15:0]      adv_reg, adv_next;
    logic             draw_reg, draw_next;

    logic             can_emit, cur_last;
    logic [34:0]      thr [10];
    logic [3:0]       digit;
    logic [34:0]      sub;
    logic [19:0]      prod;
    logic [31:0]      load_pen;

    assign glyph_valid = out_valid_reg;
    assign glyph       = out_reg;
    assign can_emit    = !out_valid_reg || !glyph_stall;
    assign cur_last    = empty_reg || (left_reg == CNT_W'(1));
    assign pop         = q_nonempty && (!act_reg || (can_emit && cur_last));

    always_comb
    begin
        thr[0] = 35'd0;
        for (int d = 1; d < 10; d++)
            thr[d] = 35'(ten_pow(pow_reg)) * 35'(d);
        digit = 4'd0;
        for (int d = 1; d < 10; d++)
        begin
            if ({3'b000, rem_reg} >= thr[d])
                digit = 4'(d);
        end
        sub = thr[digit];
    end

    always_comb
    begin
        prod     = 20'(head.glyphs) * 20'(head.advance);
        load_pen = head.left ? head.start_x
                             : head.start_x - JUSTIFY_BIAS - {12'd0, prod};
        if (head.empty)
            load_pen = 32'd0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        act_next       = act_reg;
        empty_next     = empty_reg;
        negp_next      = negp_reg;
        rem_next       = rem_reg;
        pow_next       = pow_reg;
        left_next      = left_reg;
        pen_next       = pen_reg;
        xpos_next      = xpos_reg;
        adv_next       = adv_reg;
        draw_next      = draw_reg;

        if (can_emit)
        begin
            out_valid_next = act_reg;
            if (act_reg)
            begin
                out_next.glyph_index = empty_reg ? 4'd0 : (negp_reg ? MINUS_GLYPH : digit);
                out_next.glyph_x     = empty_reg ? 32'd0 : xpos_reg;
                out_next.field_start = empty_reg ? 32'd0 : pen_reg;
                out_next.drawn       = empty_reg ? 1'b0 : draw_reg;
                out_next.empty_field = empty_reg;
                out_next.last        = cur_last;
                if (negp_reg)
                    negp_next = 1'b0;
                else
                begin
                    rem_next = rem_reg - sub[31:0];
                    if (pow_reg != '0)
                        pow_next = pow_reg - CNT_W'(1);
                end
                xpos_next = xpos_reg + {16'd0, adv_reg};
                left_next = left_reg - CNT_W'(1);
                if (cur_last)
                    act_next = 1'b0;
            end
        end

        if (pop)
        begin
            act_next   = 1'b1;
            empty_next = head.empty;
            negp_next  = head.neg;
            rem_next   = head.mag;
            pow_next   = head.ndig - CNT_W'(1);
            left_next  = head.glyphs;
            pen_next   = load_pen;
            xpos_next  = load_pen;
            adv_next   = head.advance;
            draw_next  = head.draw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            act_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            act_reg       <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        empty_reg <= empty_next;
        negp_reg  <= negp_next;
        rem_reg   <= rem_next;
        pow_reg   <= pow_next;
        left_reg  <= left_next;
        pen_reg   <= pen_next;
        xpos_reg  <= xpos_next;
        adv_reg   <= adv_next;
        draw_reg  <= draw_next;
    end

    property p_active_has_glyphs;
        @(posedge clk) disable iff (!rst_n)
        act_reg && !empty_reg |-> left_reg != '0;
    endproperty
    a_active_has_glyphs: assert property (p_active_has_glyphs)
        else $error("active field with no glyphs left");

    property p_digit_fits;
        @(posedge clk) disable iff (!rst_n)
        act_reg && !empty_reg && !negp_reg |-> {3'b000, rem_reg} < thr[9] + 35'(ten_pow(pow_reg));
    endproperty
    a_digit_fits: assert property (p_digit_fits)
        else $error("remainder exceeds current digit position");

    property p_empty_is_last;
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.empty_field |-> out_reg.last && !out_reg.drawn;
    endproperty
    a_empty_is_last: assert property (p_empty_is_last)
        else $error("empty field transaction malformed");

endmodule

// File: hw/rtl/clamped_decimal_glyph_field_unit.sv
// Top level of the clamped decimal glyph field unit.
// Instantiates cdg_front, cdg_queue and cdg_back; uses cdg_pkg.
`timescale 1ns / 1ps

// A field transaction yields one glyph transaction per cycle while
// glyph_stall is low: 1 to MAX_DIGITS glyphs for a field, a single one
// for an empty field. The glyph sequencer in the back end peels one
// decimal digit per cycle while glyph_stall is low, most significant
// first; a new field is accepted every cycle while the two-entry queue
// has room. Glyph index 10 is the minus sign; positions wrap modulo 2^32.

module clamped_decimal_glyph_field_unit
    import cdg_pkg::*;
#(
    parameter int MAX_DIGITS = 5
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      glyph_valid,
    input  logic      glyph_stall,
    output out_item_t glyph
);

    cdg_entry_t entry, head;
    logic       push, pop, q_full, q_nonempty;

    cdg_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .push       (push),
        .entry      (entry)
    );

    cdg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .din      (entry),
        .pop      (pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (head)
    );

    cdg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_nonempty  (q_nonempty),
        .head        (head),
        .pop         (pop),
        .glyph_valid (glyph_valid),
        .glyph_stall (glyph_stall),
        .glyph       (glyph)
    );

endmodule

// File: bench/tb_top.sv
// Self-checking bench for clamped_decimal_glyph_field_unit.
// Predicts each glyph transaction from the field transaction and checks the output in order.
// Depends on cdg_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_top;

    import cdg_pkg::*;

    localparam int FIELD_DIGITS    = 5;
    localparam int RAND_PER_PHASE  = 115;
    localparam int HOLD_OFF_ITEMS  = 20;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      glyph_valid;
    logic      glyph_stall;
    out_item_t glyph;

    out_item_t pending_glyphs[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    logic      hold_off_request = 1'b0;
    logic      hold_off_done = 1'b0;

    clamped_decimal_glyph_field_unit #(
        .MAX_DIGITS (FIELD_DIGITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .glyph_valid (glyph_valid),
        .glyph_stall (glyph_stall),
        .glyph       (glyph)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Expected glyph transactions for one accepted field
    task automatic predict_field(input in_item_t f);
        int                   w;
        int                   len;
        int                   n;
        int                   glyphs;
        longint               v;
        longint               lo;
        longint               hi;
        longint unsigned      mag;
        logic [3:0]           text[12];
        logic [3:0]           rev[11];
        logic [31:0]          pen;
        logic [31:0]          step;
        out_item_t            g;
        w = int'($signed(f.field_width));
        if (w < 1)
        begin
            g = '0;
            g.empty_field = 1'b1;
            g.last = 1'b1;
            pending_glyphs.push_back(g);
            return;
        end
        if (w > FIELD_DIGITS)
            w = FIELD_DIGITS;
        v = longint'($signed(f.number));
        lo = v;
        hi = v;
        case (w)
            1: begin lo = W1_LO; hi = W1_HI; end
            2: begin lo = W2_LO; hi = W2_HI; end
            3: begin lo = W3_LO; hi = W3_HI; end
            4: begin lo = W4_LO; hi = W4_HI; end
            default: ;
        endcase
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        len = 0;
        if (v < 0)
        begin
            text[0] = MINUS_GLYPH;
            len = 1;
            mag = longint'(-v);
        end
        else
            mag = v;
        n = 0;
        do
        begin
            rev[n] = 4'(mag % 10);
            n++;
            mag = mag / 10;
        end
        while (mag != 0);
        while (n > 0)
        begin
            n--;
            text[len] = rev[n];
            len++;
        end
        glyphs = (len < w) ? len : w;
        step = {16'd0, f.advance};
        pen = f.start_x;
        if (!f.left_align)
            pen = pen - JUSTIFY_BIAS - 32'(glyphs) * step;
        for (int k = 0; k < glyphs; k++)
        begin
            g.glyph_index = text[k];
            g.glyph_x = pen + 32'(k) * step;
            g.field_start = pen;
            g.drawn = f.draw_enable;
            g.empty_field = 1'b0;
            g.last = (k == glyphs - 1);
            pending_glyphs.push_back(g);
        end
    endtask

    function automatic in_item_t mk_field(input int fw, input logic [31:0] x,
                                          input logic [31:0] num, input logic [15:0] adv,
                                          input logic draw, input logic left);
        in_item_t f;
        f.field_width = 8'(fw);
        f.start_x = x;
        f.number = num;
        f.advance = adv;
        f.draw_enable = draw;
        f.left_align = left;
        return f;
    endfunction

    function automatic in_item_t random_field();
        in_item_t f;
        int       near_limits[8] = '{9, 99, 999, 9999, -9, -99, -999, 0};
        f.start_x = $urandom();
        f.advance = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 64));
        f.draw_enable = 1'($urandom());
        f.left_align = 1'($urandom());
        case ($urandom_range(0, 9))
            0: f.field_width = 8'($urandom());
            1: f.field_width = 8'(-int'($urandom_range(0, 128)));
            2: f.field_width = 8'($urandom_range(6, 127));
            default: f.field_width = 8'($urandom_range(1, 5));
        endcase
        case ($urandom_range(0, 5))
            0: f.number = $urandom();
            1: f.number = int'($urandom_range(0, 140)) - 20;
            2: f.number = near_limits[$urandom_range(0, 7)] + int'($urandom_range(0, 2)) - 1;
            3: f.number = int'($urandom_range(0, 200000)) - 100000;
            4:
            begin
                case ($urandom_range(0, 2))
                    0: f.number = 32'h8000_0000;
                    1: f.number = 32'h7fff_ffff;
                    default: f.number = 32'hffff_ffff;
                endcase
            end
            default: f.number = ($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(0, 99999));
        endcase
        return f;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_field(input in_item_t f);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= f;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_field(f);
        @(negedge clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t %s expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && glyph_valid && !glyph_stall)
        begin
            if (pending_glyphs.size() == 0)
            begin
                $display("%0t unexpected glyph transaction expected none actual %h",
                         $time, glyph);
                mismatch_count++;
            end
            else
            begin
                want = pending_glyphs.pop_front();
                check_field("glyph_index", 32'(want.glyph_index), 32'(glyph.glyph_index));
                check_field("glyph_x", want.glyph_x, glyph.glyph_x);
                check_field("field_start", want.field_start, glyph.field_start);
                check_field("drawn", 32'(want.drawn), 32'(glyph.drawn));
                check_field("empty_field", 32'(want.empty_field), 32'(glyph.empty_field));
                check_field("last", 32'(want.last), 32'(glyph.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (glyph_valid && !glyph_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Output back-pressure; the long hold-off is counted here
    initial
    begin
        glyph_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request && !hold_off_done)
            begin
                repeat (HOLD_OFF_CYCLES)
                begin
                    glyph_stall <= 1'b1;
                    @(negedge clk);
                end
                hold_off_done = 1'b1;
            end
            glyph_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic test_empty_fields();
        send_field(mk_field(0, 32'd100, 32'd5, 16'd8, 1'b1, 1'b0));
        send_field(mk_field(-1, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 1'b1, 1'b1));
        send_field(mk_field(-128, 32'h8000_0000, 32'h8000_0000, 16'd0, 1'b0, 1'b0));
    endtask

    task automatic test_width_clamps();
        send_field(mk_field(1, 32'd0, 32'd100, 16'd10, 1'b1, 1'b1));
        send_field(mk_field(1, 32'd0, -32'sd7, 16'd10, 1'b0, 1'b0));
        send_field(mk_field(2, 32'd50, -32'sd50, 16'd12, 1'b1, 1'b0));
        send_field(mk_field(2, 32'd50, 32'd500, 16'd12, 1'b1, 1'b1));
        send_field(mk_field(2, 32'd50, -32'sd3, 16'd12, 1'b0, 1'b1));
        send_field(mk_field(3, 32'd7, -32'sd1000, 16'd9, 1'b1, 1'b0));
        send_field(mk_field(3, 32'd7, 32'd5000, 16'd9, 1'b0, 1'b0));
        send_field(mk_field(4, 32'd9, -32'sd5000, 16'd16, 1'b1, 1'b1));
        send_field(mk_field(4, 32'd9, 32'd123456, 16'd16, 1'b1, 1'b0));
        send_field(mk_field(4, 32'd9, 32'd0, 16'd16, 1'b0, 1'b1));
    endtask

    task automatic test_unclamped_text();
        send_field(mk_field(127, 32'd20, 32'h8000_0000, 16'd7, 1'b1, 1'b0));
        send_field(mk_field(5, 32'd20, 32'h7fff_ffff, 16'd7, 1'b1, 1'b1));
        send_field(mk_field(5, 32'd20, 32'd12, 16'd7, 1'b0, 1'b0));
        send_field(mk_field(5, 32'd20, -32'sd5, 16'd7, 1'b1, 1'b0));
        send_field(mk_field(6, 32'd20, -32'sd123, 16'd7, 1'b0, 1'b1));
    endtask

    task automatic test_pen_wrap();
        send_field(mk_field(5, 32'h7fff_ffff, 32'd99999, 16'hffff, 1'b1, 1'b1));
        send_field(mk_field(5, 32'h8000_0000, 32'd99999, 16'hffff, 1'b1, 1'b0));
        send_field(mk_field(5, 32'd0, -32'sd8888, 16'hffff, 1'b0, 1'b0));
        send_field(mk_field(3, 32'd1, 32'd42, 16'd0, 1'b1, 1'b0));
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int hold_pct);
        send_idle_pct = idle_pct;
        stall_pct = hold_pct;
        repeat (count)
            send_field(random_field());
    endtask

    task automatic test_output_hold_off();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_request = 1'b1;
        repeat (HOLD_OFF_ITEMS)
            send_field(random_field());
        wait (hold_off_done);
        hold_off_request = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_fields();
        test_width_clamps();
        test_unclamped_text();
        test_pen_wrap();
        test_random_traffic(RAND_PER_PHASE, 8, 88);
        test_random_traffic(RAND_PER_PHASE, 88, 8);
        test_random_traffic(RAND_PER_PHASE, 0, 0);
        test_output_hold_off();

        item_valid <= 1'b0;
        while (pending_glyphs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
